// ----- hw/rtl/jsu_pkg.sv -----
// Shared types, codes and UTF-8 encode helpers for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_utf8_top.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   localparam int JSU_QUEUE_DEPTH = 4;
   localparam int CODE_W          = 21;

   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_CONTROL    = 4'd1,
      ERR_ESCAPE     = 4'd2,
      ERR_HEX        = 4'd3,
      ERR_SURROGATE  = 4'd4,
      ERR_LEAD       = 4'd5,
      ERR_TAIL       = 4'd6,
      ERR_CODE_POINT = 4'd7,
      ERR_UNTERM     = 4'd8,
      ERR_NO_QUOTE   = 4'd9
   } err_type;

   typedef enum logic [1:0] {
      JOB_CODE = 2'd0,
      JOB_DONE = 2'd1,
      JOB_ERR  = 2'd2
   } job_kind_type;

   // One queued job: a code point to encode, a done marker or an error.
   typedef struct packed {
      job_kind_type      kind;
      logic [CODE_W-1:0] code;
      err_type           err;
   } job_type;

   // Index of the final UTF-8 byte of a code point (byte count minus one).
   function automatic logic [1:0] utf8_last_idx(input logic [CODE_W-1:0] code);
      logic [1:0] n;
      if (code <= 21'h7f) begin
         n = 2'd0;
      end else if (code <= 21'h7ff) begin
         n = 2'd1;
      end else if (code <= 21'hffff) begin
         n = 2'd2;
      end else begin
         n = 2'd3;
      end
      return n;
   endfunction

   // Byte number idx of the UTF-8 form of a code point.
   function automatic logic [7:0] utf8_byte(input logic [CODE_W-1:0] code,
                                            input logic [1:0]        idx);
      logic [7:0] b;
      logic [1:0] last;
      last = utf8_last_idx(code);
      b    = 8'h00;
      case (last)
         2'd0: b = code[7:0];
         2'd1: b = (idx == 2'd0) ? {3'b110, code[10:6]} : {2'b10, code[5:0]};
         2'd2: begin
            case (idx)
               2'd0:    b = {4'b1110, code[15:12]};
               2'd1:    b = {2'b10, code[11:6]};
               default: b = {2'b10, code[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, code[20:18]};
               2'd1:    b = {2'b10, code[17:12]};
               2'd2:    b = {2'b10, code[11:6]};
               default: b = {2'b10, code[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_front.sv -----
// Front end: accepts input items and runs the string/escape/UTF-8 state machine.
// Depends on jsu_pkg; pushes result jobs into jsu_queue.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic            kind,
   input  wire logic [7:0]      data_byte,
   output logic                 push,
   output jsu_pkg::job_type     job
);
   import jsu_pkg::*;

   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_STR    = 8'b0000_0010,
      PH_ESC    = 8'b0000_0100,
      PH_HEXHI  = 8'b0000_1000,
      PH_NEEDBS = 8'b0001_0000,
      PH_NEEDU  = 8'b0010_0000,
      PH_HEXLO  = 8'b0100_0000,
      PH_TAIL   = 8'b1000_0000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CODE_W-1:0]  acc_ff, acc_in;
   logic [9:0]         hs_ff, hs_in;
   logic [2:0]         dl_ff, dl_in;
   logic [1:0]         mc_ff, mc_in;

   logic               has_result;
   logic               clear_all;
   logic [3:0]         hexv;
   logic               hex_ok;
   logic [15:0]        hex_acc;
   logic [2:0]         dl_dec;
   logic [CODE_W-1:0]  tail_acc;
   logic [CODE_W-1:0]  tail_min;

   always_comb begin
      hex_ok = 1'b1;
      hexv   = 4'd0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         hexv = data_byte[3:0];
      end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                   (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
         hexv = data_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hex_acc  = {acc_ff[11:0], hexv};
   assign dl_dec   = dl_ff - 3'd1;
   assign tail_acc = {acc_ff[14:0], data_byte[5:0]};
   assign tail_min = (mc_ff == 2'd3) ? 21'h10000 : (mc_ff == 2'd2) ? 21'h800 : 21'h80;

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      hs_in      = hs_ff;
      dl_in      = dl_ff;
      mc_in      = mc_ff;
      has_result = 1'b0;
      clear_all  = 1'b0;
      job.kind   = JOB_CODE;
      job.code   = '0;
      job.err    = ERR_NONE;

      if (kind) begin
         has_result = 1'b1;
         clear_all  = 1'b1;
         job.kind   = JOB_ERR;
         job.err    = (phase_ff == PH_IDLE) ? ERR_NO_QUOTE : ERR_UNTERM;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (data_byte == 8'h22) begin
                  phase_in = PH_STR;
               end else if (!(data_byte == 8'h20 || data_byte == 8'h0a ||
                              data_byte == 8'h0d || data_byte == 8'h09)) begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_NO_QUOTE;
               end
            end
            PH_STR: begin
               if (data_byte == 8'h22) begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_DONE;
               end else if (data_byte < 8'h20) begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_CONTROL;
               end else if (data_byte == 8'h5c) begin
                  phase_in = PH_ESC;
               end else if (data_byte < 8'h80) begin
                  has_result = 1'b1;
                  job.code   = {13'd0, data_byte};
               end else if (data_byte >= 8'hc2 && data_byte <= 8'hdf) begin
                  dl_in    = 3'd1;
                  acc_in   = {16'd0, data_byte[4:0]};
                  mc_in    = 2'd1;
                  phase_in = PH_TAIL;
               end else if (data_byte >= 8'he0 && data_byte <= 8'hef) begin
                  dl_in    = 3'd2;
                  acc_in   = {17'd0, data_byte[3:0]};
                  mc_in    = 2'd2;
                  phase_in = PH_TAIL;
               end else if (data_byte >= 8'hf0 && data_byte <= 8'hf4) begin
                  dl_in    = 3'd3;
                  acc_in   = {18'd0, data_byte[2:0]};
                  mc_in    = 2'd3;
                  phase_in = PH_TAIL;
               end else begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_LEAD;
               end
            end
            PH_ESC: begin
               phase_in = PH_STR;
               unique case (data_byte)
                  8'h22, 8'h5c, 8'h2f: begin
                     has_result = 1'b1;
                     job.code   = {13'd0, data_byte};
                  end
                  8'h62: begin has_result = 1'b1; job.code = 21'h08; end
                  8'h66: begin has_result = 1'b1; job.code = 21'h0c; end
                  8'h6e: begin has_result = 1'b1; job.code = 21'h0a; end
                  8'h72: begin has_result = 1'b1; job.code = 21'h0d; end
                  8'h74: begin has_result = 1'b1; job.code = 21'h09; end
                  8'h75: begin
                     phase_in = PH_HEXHI;
                     dl_in    = 3'd4;
                     acc_in   = '0;
                  end
                  default: begin
                     has_result = 1'b1;
                     clear_all  = 1'b1;
                     job.kind   = JOB_ERR;
                     job.err    = ERR_ESCAPE;
                  end
               endcase
            end
            PH_HEXHI, PH_HEXLO: begin
               if (!hex_ok) begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_HEX;
               end else if (dl_dec != 3'd0) begin
                  acc_in = {5'd0, hex_acc};
                  dl_in  = dl_dec;
               end else begin
                  acc_in = '0;
                  dl_in  = 3'd0;
                  if (phase_ff == PH_HEXHI) begin
                     if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                        hs_in    = hex_acc[9:0];
                        phase_in = PH_NEEDBS;
                     end else if (hex_acc >= 16'hdc00) begin
                        // A lone low surrogate (0xdc00 up to 0xdfff) is refused;
                        // anything above 0xdfff is an ordinary BMP code point.
                        if (hex_acc <= 16'hdfff) begin
                           has_result = 1'b1;
                           clear_all  = 1'b1;
                           job.kind   = JOB_ERR;
                           job.err    = ERR_SURROGATE;
                        end else begin
                           phase_in   = PH_STR;
                           has_result = 1'b1;
                           job.code   = {5'd0, hex_acc};
                        end
                     end else begin
                        phase_in   = PH_STR;
                        has_result = 1'b1;
                        job.code   = {5'd0, hex_acc};
                     end
                  end else begin
                     if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                        has_result = 1'b1;
                        clear_all  = 1'b1;
                        job.kind   = JOB_ERR;
                        job.err    = ERR_SURROGATE;
                     end else begin
                        hs_in      = '0;
                        phase_in   = PH_STR;
                        has_result = 1'b1;
                        job.code   = 21'h10000 + {1'b0, hs_ff, hex_acc[9:0]};
                     end
                  end
               end
            end
            PH_NEEDBS: begin
               if (data_byte == 8'h5c) begin
                  phase_in = PH_NEEDU;
               end else begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_SURROGATE;
               end
            end
            PH_NEEDU: begin
               if (data_byte == 8'h75) begin
                  phase_in = PH_HEXLO;
                  dl_in    = 3'd4;
                  acc_in   = '0;
               end else begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_SURROGATE;
               end
            end
            PH_TAIL: begin
               if (data_byte[7:6] != 2'b10) begin
                  has_result = 1'b1;
                  clear_all  = 1'b1;
                  job.kind   = JOB_ERR;
                  job.err    = ERR_TAIL;
               end else if (dl_dec != 3'd0) begin
                  acc_in = tail_acc;
                  dl_in  = dl_dec;
               end else begin
                  acc_in = '0;
                  dl_in  = 3'd0;
                  mc_in  = 2'd0;
                  if (tail_acc < tail_min || tail_acc > 21'h10ffff ||
                      (tail_acc >= 21'hd800 && tail_acc <= 21'hdfff)) begin
                     has_result = 1'b1;
                     clear_all  = 1'b1;
                     job.kind   = JOB_ERR;
                     job.err    = ERR_CODE_POINT;
                  end else begin
                     phase_in   = PH_STR;
                     has_result = 1'b1;
                     job.code   = tail_acc;
                  end
               end
            end
            default: begin
               clear_all = 1'b1;
            end
         endcase
      end

      // Every error or done result returns all state to its reset value.
      if (clear_all) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         hs_in    = '0;
         dl_in    = '0;
         mc_in    = '0;
      end
   end

   assign push = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         hs_ff    <= '0;
         dl_ff    <= '0;
         mc_ff    <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
         dl_ff    <= dl_in;
         mc_ff    <= mc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_queue.sv -----
// Short job queue between front end and back end of the unescaper.
// Depends on jsu_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
   parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire jsu_pkg::job_type push_job,
   input  wire logic            pop,
   output logic                 full,
   output logic                 not_empty,
   output jsu_pkg::job_type     head_job
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_back.sv -----
// Back end: turns queued jobs into result items, one UTF-8 byte or status per item.
// Depends on jsu_pkg for the job type and the UTF-8 encode functions.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            head_valid,
   input  wire jsu_pkg::job_type head_job,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last,
   output logic                 rsp_done_res,
   output logic [3:0]           rsp_error_code
);
   import jsu_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  idx_ff, idx_in;
   logic [7:0]  byte_ff, byte_in;
   logic        bvalid_ff, bvalid_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;
   err_type     err_ff, err_in;
   logic        load;

   // A waiting queue head is loaded whenever the output register is empty or being taken.
   assign load = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      byte_in   = 8'h00;
      bvalid_in = 1'b0;
      last_in   = 1'b1;
      done_in   = 1'b0;
      err_in    = ERR_NONE;
      case (head_job.kind)
         JOB_CODE: begin
            byte_in   = utf8_byte(head_job.code, idx_ff);
            bvalid_in = 1'b1;
            last_in   = (idx_ff == utf8_last_idx(head_job.code));
         end
         JOB_DONE: done_in = 1'b1;
         default:  err_in  = head_job.err;
      endcase
      pop      = load && last_in;
      idx_in   = load ? (last_in ? 2'd0 : idx_ff + 2'd1) : idx_ff;
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         last_ff   <= last_in;
         done_ff   <= done_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bvalid_ff;
   assign rsp_last       = last_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_error_code = err_ff;

`ifndef SYNTHESIS
   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");
   a_mid_job_holds_head: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> head_valid && (head_job.kind == JOB_CODE))
      else $error("multi-byte code point lost its queue entry");
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid) |-> rsp_last)
      else $error("done or error item not marked last");
   a_error_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ERR_NONE) |-> !rsp_byte_valid && !rsp_done_res)
      else $error("error item carries a byte or done flag");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_top.sv -----
// Top level of the streaming JSON string unescaper with UTF-8 validation.
// Depends on jsu_pkg and instantiates jsu_front, jsu_queue and jsu_back.
// The front end takes one input item per clock cycle unless the queue is full:
// it skips blanks, checks the opening quote, decodes escapes and \uXXXX (joining
// surrogate pairs) and validates raw UTF-8. Every item that yields output
// becomes one job in a short queue (QUEUE_DEPTH entries). The back end drains
// the queue and sends one result item per cycle while rsp_stall is low, through
// a registered output: a code point gives one to four byte items, a closing
// quote gives one done item and a violation gives one error item, after which
// the decoder is idle again. Items that yield nothing (blanks, escape starts,
// lead bytes, hex digits and continuation bytes that end no character) never
// reach the queue. So input runs at one item per cycle while the output keeps
// up; a code point leaves the queue with its last byte, and req_stall rises only
// when the queue is full. It has no configuration registers or clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top #(
   parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_last,
   output logic             rsp_done_res,
   output logic [3:0]       rsp_error_code
);
   import jsu_pkg::*;

   logic     accept;
   logic     push;
   logic     pop;
   logic     q_full;
   logic     q_not_empty;
   job_type  front_job;
   job_type  head_job;

   // The input side is held off only by a full queue, never by the output.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   jsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_kind),
      .data_byte (req_data_byte),
      .push      (push),
      .job       (front_job)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_job  (head_job)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_not_empty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_error_code (rsp_error_code)
   );

endmodule

`default_nettype wire

// ----- verif/tb_json_string_unescape_utf8_top.sv -----
// Self-checking testbench for json_string_unescape_utf8_top, the JSON string decoder.
// It depends on jsu_pkg for the error codes. A scoreboard class decodes every
// accepted input item on its own and checks each result item in order.
`timescale 1ns / 1ps

import jsu_pkg::*;

// Characters that steer the decoder.
localparam logic [7:0] CH_TAB    = 8'h09;
localparam logic [7:0] CH_LF     = 8'h0a;
localparam logic [7:0] CH_CR     = 8'h0d;
localparam logic [7:0] CH_SPACE  = 8'h20;
localparam logic [7:0] CH_QUOTE  = 8'h22;
localparam logic [7:0] CH_SLASH  = 8'h2f;
localparam logic [7:0] CH_BSLASH = 8'h5c;

// Where the decoder stands inside a string literal.
typedef enum logic [2:0] {
   SCAN_IDLE,       // outside a string, waiting for the opening quote
   SCAN_BODY,       // inside the string body
   SCAN_ESCAPE,     // after a backslash
   SCAN_HEX_HIGH,   // hex digits of a first \u escape
   SCAN_NEED_BS,    // high surrogate seen, backslash must follow
   SCAN_NEED_U,     // high surrogate and backslash seen, 'u' must follow
   SCAN_HEX_LOW,    // hex digits of the low surrogate escape
   SCAN_UTF8_TAIL   // continuation bytes of a raw UTF-8 sequence
} scan_phase_type;

typedef struct packed {
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last;
   logic       done_res;
   err_type    error_code;
} unescape_result_type;

// UTF-8 form of a code point; returns the number of bytes.
function automatic int utf8_encode(input logic [20:0] cp, output logic [7:0] enc [4]);
   enc = '{default: 8'h00};
   if (cp <= 21'h00007f) begin
      enc[0] = cp[7:0];
      return 1;
   end
   if (cp <= 21'h0007ff) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      return 2;
   end
   if (cp <= 21'h00ffff) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      return 3;
   end
   enc[0] = {5'b11110, cp[20:18]};
   enc[1] = {2'b10, cp[17:12]};
   enc[2] = {2'b10, cp[11:6]};
   enc[3] = {2'b10, cp[5:0]};
   return 4;
endfunction

class unescape_scoreboard;
   scan_phase_type      phase;
   logic [20:0]         code_acc;
   logic [9:0]          high_half;
   logic [2:0]          digits_due;
   logic [1:0]          min_class;
   unescape_result_type due[$];
   int unsigned         mismatches;

   function new();
      clear_state();
      mismatches = 0;
   endfunction

   function void clear_state();
      phase      = SCAN_IDLE;
      code_acc   = '0;
      high_half  = '0;
      digits_due = '0;
      min_class  = '0;
   endfunction

   function int unsigned outstanding();
      return due.size();
   endfunction

   function void queue_result(logic [7:0] b, logic bv, logic l, logic d, err_type e);
      unescape_result_type r;
      r.out_byte   = b;
      r.byte_valid = bv;
      r.last       = l;
      r.done_res   = d;
      r.error_code = e;
      due.insert(due.size(), r);
   endfunction

   function void raise_error(err_type e);
      clear_state();
      queue_result(8'h00, 1'b0, 1'b1, 1'b0, e);
   endfunction

   function void emit_code_point(logic [20:0] cp);
      logic [7:0] enc [4];
      int         n;
      n = utf8_encode(cp, enc);
      for (int i = 0; i < n; i++)
         queue_result(enc[i], 1'b1, i == n - 1, 1'b0, ERR_NONE);
   endfunction

   function int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
   endfunction

   // Decode one accepted input item and queue the result items it causes.
   function void take_request(logic kind, logic [7:0] c);
      int          h;
      logic [20:0] cp;
      logic [20:0] floor_cp;
      if (kind) begin
         raise_error(phase == SCAN_IDLE ? ERR_NO_QUOTE : ERR_UNTERM);
         return;
      end
      case (phase)
         SCAN_IDLE: begin
            if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) return;
            if (c == CH_QUOTE) begin
               phase = SCAN_BODY;
               return;
            end
            raise_error(ERR_NO_QUOTE);
         end
         SCAN_BODY: begin
            if (c == CH_QUOTE) begin
               clear_state();
               queue_result(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            end else if (c < 8'h20) begin
               raise_error(ERR_CONTROL);
            end else if (c == CH_BSLASH) begin
               phase = SCAN_ESCAPE;
            end else if (c < 8'h80) begin
               emit_code_point({13'h0, c});
            end else if (c >= 8'hc2 && c <= 8'hdf) begin
               digits_due = 3'd1;
               code_acc   = {16'h0, c[4:0]};
               min_class  = 2'd1;
               phase      = SCAN_UTF8_TAIL;
            end else if (c >= 8'he0 && c <= 8'hef) begin
               digits_due = 3'd2;
               code_acc   = {17'h0, c[3:0]};
               min_class  = 2'd2;
               phase      = SCAN_UTF8_TAIL;
            end else if (c >= 8'hf0 && c <= 8'hf4) begin
               digits_due = 3'd3;
               code_acc   = {18'h0, c[2:0]};
               min_class  = 2'd3;
               phase      = SCAN_UTF8_TAIL;
            end else begin
               raise_error(ERR_LEAD);
            end
         end
         SCAN_ESCAPE: begin
            phase = SCAN_BODY;
            case (c)
               CH_QUOTE, CH_BSLASH, CH_SLASH: emit_code_point({13'h0, c});
               "b": emit_code_point(21'h08);
               "f": emit_code_point(21'h0c);
               "n": emit_code_point(21'h0a);
               "r": emit_code_point(21'h0d);
               "t": emit_code_point(21'h09);
               "u": begin
                  phase      = SCAN_HEX_HIGH;
                  digits_due = 3'd4;
                  code_acc   = '0;
               end
               default: raise_error(ERR_ESCAPE);
            endcase
         end
         SCAN_HEX_HIGH, SCAN_HEX_LOW: begin
            h = hex_value(c);
            if (h < 0) begin
               raise_error(ERR_HEX);
               return;
            end
            code_acc   = ((code_acc << 4) | 21'(h)) & 21'h00ffff;
            digits_due = digits_due - 3'd1;
            if (digits_due != 0) return;
            cp       = code_acc;
            code_acc = '0;
            if (phase == SCAN_HEX_HIGH) begin
               if (cp >= 21'h00d800 && cp <= 21'h00dbff) begin
                  high_half = 10'(cp - 21'h00d800);
                  phase     = SCAN_NEED_BS;
               end else if (cp >= 21'h00dc00 && cp <= 21'h00dfff) begin
                  raise_error(ERR_SURROGATE);
               end else begin
                  phase = SCAN_BODY;
                  emit_code_point(cp);
               end
               return;
            end
            if (cp < 21'h00dc00 || cp > 21'h00dfff) begin
               raise_error(ERR_SURROGATE);
               return;
            end
            cp        = 21'h010000 + {1'b0, high_half, 10'h000} + (cp - 21'h00dc00);
            high_half = '0;
            phase     = SCAN_BODY;
            emit_code_point(cp);
         end
         SCAN_NEED_BS: begin
            if (c != CH_BSLASH) raise_error(ERR_SURROGATE);
            else phase = SCAN_NEED_U;
         end
         SCAN_NEED_U: begin
            if (c != "u") begin
               raise_error(ERR_SURROGATE);
            end else begin
               phase      = SCAN_HEX_LOW;
               digits_due = 3'd4;
               code_acc   = '0;
            end
         end
         default: begin
            if (c[7:6] != 2'b10) begin
               raise_error(ERR_TAIL);
               return;
            end
            code_acc   = ((code_acc << 6) | {15'h0, c[5:0]}) & 21'h1fffff;
            digits_due = digits_due - 3'd1;
            if (digits_due != 0) return;
            cp = code_acc;
            case (min_class)
               2'd3:    floor_cp = 21'h010000;
               2'd2:    floor_cp = 21'h000800;
               default: floor_cp = 21'h000080;
            endcase
            code_acc  = '0;
            min_class = '0;
            if (cp < floor_cp || cp > 21'h10ffff || (cp >= 21'h00d800 && cp <= 21'h00dfff)) begin
               raise_error(ERR_CODE_POINT);
               return;
            end
            phase = SCAN_BODY;
            emit_code_point(cp);
         end
      endcase
   endfunction

   // Compare one accepted result item with the oldest expected one.
   function void check_response(logic [7:0] b, logic bv, logic l, logic d, logic [3:0] e);
      unescape_result_type x;
      if (due.size() == 0) begin
         $error("result item with nothing expected: out_byte %02h error_code %0d", b, e);
         mismatches++;
         return;
      end
      x = due.pop_front();
      if (b !== x.out_byte) begin
         $error("out_byte: expected %02h, actual %02h", x.out_byte, b);
         mismatches++;
      end
      if (bv !== x.byte_valid) begin
         $error("byte_valid: expected %0b, actual %0b", x.byte_valid, bv);
         mismatches++;
      end
      if (l !== x.last) begin
         $error("last: expected %0b, actual %0b", x.last, l);
         mismatches++;
      end
      if (d !== x.done_res) begin
         $error("done_res: expected %0b, actual %0b", x.done_res, d);
         mismatches++;
      end
      if (e !== x.error_code) begin
         $error("error_code: expected %0d, actual %0d", x.error_code, e);
         mismatches++;
      end
   endfunction
endclass

module tb_json_string_unescape_utf8_top;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 9;
   // Cycles in a row with no item accepted on either side before giving up.
   localparam int QUIET_LIMIT  = 2000;
   // Margin at the end of the run for the queue and the output register to settle.
   localparam int TAIL_CYCLES  = 20;
   localparam int RANDOM_ITEMS = 40;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_kind      = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last;
   logic       rsp_done_res;
   logic [3:0] rsp_error_code;

   // Idle rates in percent for the sending and the receiving side.
   int unsigned send_idle_pct  = 33;
   int unsigned recv_stall_pct = 74;

   unescape_scoreboard sb;

   // Items waiting to be sent: bit 8 is the kind, bits 7:0 the byte.
   logic [8:0] script[$];
   int         random_items;
   int         quiet_cycles = 0;

   always #HALF_PERIOD clock = ~clock;

   json_string_unescape_utf8_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_done_res   (rsp_done_res),
      .rsp_error_code (rsp_error_code)
   );

   // The receiver decides at each falling edge whether to hold off the next result.
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Every result item accepted at a rising edge is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_out_byte, rsp_byte_valid, rsp_last, rsp_done_res,
                           rsp_error_code);
   end

   // The watchdog ends a run that has stopped moving on both channels.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic add_item(input logic kind, input logic [7:0] b);
      script.insert(script.size(), {kind, b});
   endtask

   task automatic add_ascii(input string s);
      for (int i = 0; i < s.len(); i++)
         add_item(1'b0, s[i]);
   endtask

   // One hex digit, with letters in either case.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
   endfunction

   task automatic add_hex4(input logic [15:0] v);
      for (int i = 3; i >= 0; i--)
         add_item(1'b0, hex_char(v[i*4 +: 4]));
   endtask

   // Called at a falling edge. Presents one item after an optional gap, holds it
   // until it is accepted and returns at the following falling edge.
   task automatic send_item(input logic [8:0] it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_kind      = it[8];
      req_data_byte = it[7:0];
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      sb.take_request(it[8], it[7:0]);
      @(negedge clock);
   endtask

   task automatic play_script();
      foreach (script[i])
         send_item(script[i]);
      script.delete();
   endtask

   // The sender holds off until every expected result item has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (sb.outstanding() != 0)
         @(negedge clock);
   endtask

   // Builds one string literal with random content. Most come out well formed;
   // some get a byte replaced or are cut short by an end of input, and a few
   // gain a stray item so that the decoder also sees noise.
   task automatic build_string();
      string       esc_letters;
      logic [20:0] cp;
      logic [15:0] low_half;
      logic [7:0]  enc [4];
      int          n;
      int          blanks;
      int          cut;
      int          pick;
      esc_letters = "\"\\/bfnrt";
      blanks = $urandom_range(0, 2);
      for (int i = 0; i < blanks; i++) begin
         case ($urandom_range(0, 3))
            0:       add_item(1'b0, CH_SPACE);
            1:       add_item(1'b0, CH_LF);
            2:       add_item(1'b0, CH_CR);
            default: add_item(1'b0, CH_TAB);
         endcase
      end
      add_item(1'b0, CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 5))
            0: begin
               cp = $urandom_range(8'h20, 8'h7e);
               if (cp[7:0] == CH_QUOTE || cp[7:0] == CH_BSLASH) cp = 21'h61;
               add_item(1'b0, cp[7:0]);
            end
            1: begin
               add_item(1'b0, CH_BSLASH);
               add_item(1'b0, esc_letters[$urandom_range(0, esc_letters.len() - 1)]);
            end
            2: begin
               // A \u escape that stands alone must not fall on a surrogate.
               cp = $urandom_range(0, 16'hffff);
               if (cp >= 21'h00d800 && cp <= 21'h00dfff) cp = cp ^ 21'h004000;
               add_ascii("\\u");
               add_hex4(cp[15:0]);
            end
            3: begin
               cp       = $urandom_range(16'hd800, 16'hdbff);
               low_half = $urandom_range(16'hdc00, 16'hdfff);
               add_ascii("\\u");
               add_hex4(cp[15:0]);
               add_ascii("\\u");
               add_hex4(low_half);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: cp = $urandom_range(12'h080, 12'h7ff);
                  1: begin
                     cp = $urandom_range(16'h0800, 16'hffff);
                     if (cp >= 21'h00d800 && cp <= 21'h00dfff) cp = cp ^ 21'h004000;
                  end
                  default: cp = $urandom_range(21'h010000, 21'h10ffff);
               endcase
               n = utf8_encode(cp, enc);
               for (int i = 0; i < n; i++)
                  add_item(1'b0, enc[i]);
            end
         endcase
      end
      add_item(1'b0, CH_QUOTE);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         script[$urandom_range(blanks, script.size() - 1)] = {1'b0, 8'($urandom)};
      end else if (pick < 22) begin
         cut    = $urandom_range(blanks + 1, script.size() - 1);
         script = script[0:cut-1];
         add_item(1'b1, 8'($urandom));
      end
      if ($urandom_range(0, 99) < 10)
         add_item($urandom_range(0, 3) == 0, 8'($urandom));
      random_items += script.size() - blanks;
   endtask

   initial begin
      int stage;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Each line leaves the decoder in a known place.
      add_item(1'b1, 8'hff);             // end of input before any string
      add_item(1'b0, 8'h00);             // stray byte while idle
      add_ascii(" \t\"");                // blanks, then the opening quote
      add_item(1'b0, 8'h7f);             // largest one-byte character
      add_ascii("\\udBfF\\uDffF");       // surrogate pair for the top code point
      add_item(1'b0, 8'hf4);             // the same code point in raw form
      add_item(1'b0, 8'h8f);
      add_item(1'b0, 8'hbf);
      add_item(1'b0, 8'hbf);
      add_item(1'b0, 8'h1f);             // raw control character
      add_ascii("\"\\q");                // unknown escape letter
      add_item(1'b0, CH_QUOTE);
      add_item(1'b0, 8'hc2);             // smallest two-byte character
      add_item(1'b0, 8'h80);
      add_item(1'b0, 8'he0);             // overlong three-byte form
      add_item(1'b0, 8'h80);
      add_item(1'b0, 8'h80);
      add_item(1'b0, CH_QUOTE);
      add_item(1'b0, 8'hff);             // byte that can never lead
      add_ascii("\"\\uZ");               // bad hex digit
      add_ascii("\"\\uDC00");            // low surrogate on its own
      add_ascii("\"\\uD800A");           // high surrogate not followed by an escape
      add_item(1'b0, CH_QUOTE);
      add_item(1'b0, 8'hc3);             // lead byte followed by plain ASCII
      add_item(1'b0, 8'h28);
      add_ascii("\"\"");                 // empty string
      add_item(1'b0, CH_QUOTE);
      add_item(1'b0, 8'he2);             // input ends inside a sequence
      add_item(1'b1, 8'h00);
      play_script();
      wait_drained();

      // Random part in three stages of idling, each with at least one string;
      // between stages the sender waits for every outstanding result item.
      random_items = 0;
      for (stage = 0; stage < 3; stage++) begin
         if (stage == 1) begin
            wait_drained();
            send_idle_pct  = 74;
            recv_stall_pct = 33;
         end else if (stage == 2) begin
            wait_drained();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         do begin
            build_string();
            play_script();
         end while (random_items < (stage + 1) * RANDOM_ITEMS / 3);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
